/* hdl/tao_pkg.sv */
package tao_pkg;

  localparam int RATIO_W = 9;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd128;
  localparam int FRAC_BITS = 8;
  localparam int TRACK_INDEX_W = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_WRITE
  } back_state_t;

endpackage

/* hdl/tao_if.sv */
interface tao_rect_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] rect_x;
  logic [COORD_BITS-1:0] rect_y;
  logic [COORD_BITS:0]   rect_width;
  logic [COORD_BITS:0]   rect_height;

  modport source (output valid, output rect_x, output rect_y, output rect_width,
                  output rect_height, input ready);
  modport sink (input valid, input rect_x, input rect_y, input rect_width,
                input rect_height, output ready);
endinterface

interface tao_result_if;
  logic                             valid;
  logic                             ready;
  logic [tao_pkg::TRACK_INDEX_W-1:0] track_index;
  logic                             opened_new;
  logic                             table_full;

  modport source (output valid, output track_index, output opened_new,
                  output table_full, input ready);
  modport sink (input valid, input track_index, input opened_new,
                input table_full, output ready);
endinterface

interface tao_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tao_pkg::RATIO_W-1:0] same_object_ratio;

  modport source (output valid, output same_object_ratio, input ready);
  modport sink (input valid, input same_object_ratio, output ready);
endinterface

/* hdl/tao_front.sv */
module tao_front #(
  parameter int COORD_BITS = 12,
  localparam int CW = COORD_BITS,
  localparam int SW = COORD_BITS + 1,
  localparam int WH_W = 2 * SW,
  localparam int PW = tao_pkg::RATIO_W + WH_W,
  localparam int DATA_W = 2 * CW + 2 * SW + PW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tao_rect_if.sink                    in_rect,
  input  logic [tao_pkg::RATIO_W-1:0] ratio,
  input  tao_pkg::q_status_t          q_stat,
  output logic                        push,
  output logic [DATA_W-1:0]           push_data
);

  logic          f1_v_r;
  logic          f2_v_r;
  logic [CW-1:0] f1_x_r, f1_y_r, f2_x_r, f2_y_r;
  logic [SW-1:0] f1_w_r, f1_h_r, f2_w_r, f2_h_r;
  logic [WH_W-1:0] f1_wh_r;
  logic [PW-1:0]   f2_ra_r;
  logic          f1_go;
  logic          f2_go;
  logic          take;

  // stage 2 leaves when the queue has room, stage 1 when stage 2 is free
  assign f2_go = f2_v_r && !q_stat.full;
  assign f1_go = f1_v_r && (!f2_v_r || f2_go);
  assign in_rect.ready = !f1_v_r || f1_go;
  assign take = in_rect.valid && in_rect.ready;

  assign push = f2_go;
  assign push_data = {f2_x_r, f2_y_r, f2_w_r, f2_h_r, f2_ra_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      if (take) begin
        f1_v_r <= 1'b1;
      end else if (f1_go) begin
        f1_v_r <= 1'b0;
      end
      if (f1_go) begin
        f2_v_r <= 1'b1;
      end else if (f2_go) begin
        f2_v_r <= 1'b0;
      end
    end
  end

  // own area of the new rectangle, then scaled by the ratio
  always_ff @(posedge clk) begin
    if (take) begin
      f1_x_r  <= in_rect.rect_x;
      f1_y_r  <= in_rect.rect_y;
      f1_w_r  <= in_rect.rect_width;
      f1_h_r  <= in_rect.rect_height;
      f1_wh_r <= WH_W'(in_rect.rect_width) * WH_W'(in_rect.rect_height);
    end
    if (f1_go) begin
      f2_x_r  <= f1_x_r;
      f2_y_r  <= f1_y_r;
      f2_w_r  <= f1_w_r;
      f2_h_r  <= f1_h_r;
      f2_ra_r <= PW'(ratio) * PW'(f1_wh_r);
    end
  end

endmodule

/* hdl/tao_queue.sv */
module tao_queue #(
  parameter int DATA_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [DATA_W-1:0]  push_data,
  input  logic               pop,
  output logic [DATA_W-1:0]  pop_data,
  output tao_pkg::q_status_t stat
);

  logic [DATA_W-1:0]          entry_r [tao_pkg::QUEUE_DEPTH];
  logic [tao_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [tao_pkg::QCNT_W-1:0] cnt_r;

  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == tao_pkg::QCNT_W'(tao_pkg::QUEUE_DEPTH));
  assign pop_data   = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == tao_pkg::QPTR_W'(tao_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == tao_pkg::QPTR_W'(tao_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_data;
    end
  end

endmodule

/* hdl/tao_back.sv */
module tao_back #(
  parameter int MAX_TRACKS = 64,
  parameter int COORD_BITS = 12,
  localparam int CW = COORD_BITS,
  localparam int SW = COORD_BITS + 1,
  localparam int PW = tao_pkg::RATIO_W + 2 * SW,
  localparam int DATA_W = 2 * CW + 2 * SW + PW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tao_pkg::RATIO_W-1:0] ratio,
  input  tao_pkg::q_status_t          q_stat,
  output logic                        pop,
  input  logic [DATA_W-1:0]           pop_data,
  tao_result_if.source                out_res
);

  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int REC_W = 2 * CW + 2 * SW;
  localparam int DW = CW + 2;
  localparam int AW = 2 * DW;
  localparam int BWH_W = 2 * SW;
  localparam int CMP_W = AW + tao_pkg::FRAC_BITS;
  localparam int TIW = tao_pkg::TRACK_INDEX_W;

  tao_pkg::back_state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             match_r, match_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic [REC_W-1:0] cur_rec_r;
  logic [PW-1:0]    cur_ra_r;

  logic [REC_W-1:0] mem [MAX_TRACKS];
  logic [REC_W-1:0] rd_data_r;
  logic             we;
  logic [IDX_W-1:0] wa;

  logic             out_valid_r, out_valid_nxt;
  logic [TIW-1:0]   out_idx_r, out_idx_nxt;
  logic             out_new_r, out_new_nxt;
  logic             out_full_r, out_full_nxt;
  logic             out_free;

  logic             issue, run, hit, load;

  logic             s1_v_r, s1_last_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s2_v_r, s2_last_r, s2_ok_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [DW-1:0]    s2_dx_r, s2_dy_r;
  logic [SW-1:0]    s2_bw_r, s2_bh_r;
  logic             s3_v_r, s3_last_r, s3_ok_r;
  logic [IDX_W-1:0] s3_idx_r;
  logic [AW-1:0]    s3_area_r;
  logic [BWH_W-1:0] s3_bwh_r;
  logic             s4_v_r, s4_last_r, s4_ok_r;
  logic [IDX_W-1:0] s4_idx_r;
  logic [AW-1:0]    s4_area_r;
  logic [PW-1:0]    s4_rb_r;

  logic [CW-1:0] ax, ay, bx, by, lx, ly, rx, ry;
  logic [SW-1:0] aw, ah, bw, bh, lw, lh, rh;
  logic          swap, ok_x, c1, c2;
  logic [DW-1:0] dx, dy;
  logic [CMP_W-1:0] lhs;
  logic [TIW+IDX_W-1:0] idx_ext;

  // same-object test on the track rectangle just read
  always_comb begin
    {ax, ay, aw, ah} = cur_rec_r;
    {bx, by, bw, bh} = rd_data_r;
    swap = (ax > bx);
    lx = swap ? bx : ax;
    ly = swap ? by : ay;
    lw = swap ? bw : aw;
    lh = swap ? bh : ah;
    rx = swap ? ax : bx;
    ry = swap ? ay : by;
    rh = swap ? ah : bh;
    ok_x = ({1'b0, rx - lx} < lw);
    c1 = (ly <= ry) && (lh > {1'b0, ry - ly});
    c2 = (ly >= ry) && (rh > {1'b0, ly - ry});
    dx = DW'(lx) + DW'(lw) - DW'(rx);
    dy = c1 ? (DW'(ly) + DW'(lh) - DW'(ry)) : (DW'(ry) + DW'(rh) - DW'(ly));
  end

  assign lhs = {s4_area_r, tao_pkg::FRAC_BITS'(0)};
  assign hit = s4_v_r && s4_ok_r && ((lhs > CMP_W'(cur_ra_r)) || (lhs > CMP_W'(s4_rb_r)));

  assign issue = (state_r == tao_pkg::B_SCAN) && (iss_r < cnt_r);
  assign run   = (state_r == tao_pkg::B_SCAN) && !hit;
  assign out_free = !out_valid_r || out_res.ready;

  assign out_res.valid       = out_valid_r;
  assign out_res.track_index = out_idx_r;
  assign out_res.opened_new  = out_new_r;
  assign out_res.table_full  = out_full_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;
    pop           = 1'b0;
    load          = 1'b0;
    we            = 1'b0;
    wa            = match_r ? match_idx_r : cnt_r[IDX_W-1:0];
    idx_ext       = {TIW'(0), wa};
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      tao_pkg::B_IDLE: begin
        if (q_stat.valid) begin
          pop       = 1'b1;
          load      = 1'b1;
          iss_nxt   = '0;
          match_nxt = 1'b0;
          state_nxt = (cnt_r == '0) ? tao_pkg::B_WRITE : tao_pkg::B_SCAN;
        end
      end
      tao_pkg::B_SCAN: begin
        if (issue) begin
          iss_nxt = iss_r + 1'b1;
        end
        if (hit) begin
          match_nxt     = 1'b1;
          match_idx_nxt = s4_idx_r;
          state_nxt     = tao_pkg::B_WRITE;
        end else if (s4_v_r && s4_last_r) begin
          state_nxt = tao_pkg::B_WRITE;
        end
      end
      tao_pkg::B_WRITE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = tao_pkg::B_IDLE;
          if (match_r) begin
            we           = 1'b1;
            out_idx_nxt  = idx_ext[TIW-1:0];
            out_new_nxt  = 1'b0;
            out_full_nxt = 1'b0;
          end else if (cnt_r < CNT_W'(MAX_TRACKS)) begin
            we           = 1'b1;
            cnt_nxt      = cnt_r + 1'b1;
            out_idx_nxt  = idx_ext[TIW-1:0];
            out_new_nxt  = 1'b1;
            out_full_nxt = 1'b0;
          end else begin
            out_idx_nxt  = '0;
            out_new_nxt  = 1'b0;
            out_full_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = tao_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tao_pkg::B_IDLE;
      cnt_r       <= '0;
      iss_r       <= '0;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      iss_r       <= iss_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r      <= issue && !hit;
      s2_v_r      <= s1_v_r && run;
      s3_v_r      <= s2_v_r && run;
      s4_v_r      <= s3_v_r && run;
    end
  end

  always_ff @(posedge clk) begin
    match_idx_r <= match_idx_nxt;
    out_idx_r   <= out_idx_nxt;
    out_new_r   <= out_new_nxt;
    out_full_r  <= out_full_nxt;
    if (load) begin
      cur_rec_r <= pop_data[DATA_W-1:PW];
      cur_ra_r  <= pop_data[PW-1:0];
    end
    s1_idx_r  <= iss_r[IDX_W-1:0];
    s1_last_r <= (iss_r + 1'b1 == cnt_r);
    s2_idx_r  <= s1_idx_r;
    s2_last_r <= s1_last_r;
    s2_ok_r   <= ok_x && (c1 || c2);
    s2_dx_r   <= dx;
    s2_dy_r   <= dy;
    s2_bw_r   <= bw;
    s2_bh_r   <= bh;
    s3_idx_r  <= s2_idx_r;
    s3_last_r <= s2_last_r;
    s3_ok_r   <= s2_ok_r;
    s3_area_r <= AW'(s2_dx_r) * AW'(s2_dy_r);
    s3_bwh_r  <= BWH_W'(s2_bw_r) * BWH_W'(s2_bh_r);
    s4_idx_r  <= s3_idx_r;
    s4_last_r <= s3_last_r;
    s4_ok_r   <= s3_ok_r;
    s4_area_r <= s3_area_r;
    s4_rb_r   <= PW'(ratio) * PW'(s3_bwh_r);
  end

  // track table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= cur_rec_r;
    end
    if (issue) begin
      rd_data_r <= mem[iss_r[IDX_W-1:0]];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TRACKS))
    else $error("track count above table size");

  a_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> state_r == tao_pkg::B_SCAN)
    else $error("compare result outside scan");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_new_r && out_full_r))
    else $error("new track and table full together");

  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tao_pkg::B_WRITE && out_free && !match_r && cnt_r < CNT_W'(MAX_TRACKS))
    |=> cnt_r == CNT_W'($past(cnt_r) + 1'b1))
    else $error("track count not advanced on new track");

endmodule

/* hdl/track_assign_by_overlap_core.sv */
// Assigns each detected rectangle to a track by overlap. A front stage takes one rectangle
// per transaction and precomputes its area, then its scaled area, in registers f1 and f2;
// a two-entry queue hands it to the back end, which reads the stored tracks from a table
// with one read and one write port, one track per cycle, through a four-stage compare
// pipeline, and stops at the first match. An item holds the back end through its scan and
// until the result register is free; the front end overlaps with it. Only one transaction
// on the cfg_ port, the overlap ratio in Q1.8 (reset 128); the user must write it only
// while no item is in flight, and the block does not enforce this. Results leave from an
// output register, so the next item proceeds while one waits.
module track_assign_by_overlap_core #(
  parameter int MAX_TRACKS = 64,
  parameter int COORD_BITS = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  tao_rect_if.sink     in_rect,
  tao_result_if.source out_res,
  tao_cfg_if.sink      cfg_wr
);

  localparam int SW = COORD_BITS + 1;
  localparam int PW = tao_pkg::RATIO_W + 2 * SW;
  localparam int DATA_W = 2 * COORD_BITS + 2 * SW + PW;

  logic [tao_pkg::RATIO_W-1:0] ratio_r;
  tao_pkg::q_status_t          q_stat;
  logic                        push, pop;
  logic [DATA_W-1:0]           push_data, pop_data;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= tao_pkg::RATIO_RESET;
    end else if (cfg_wr.valid) begin
      ratio_r <= cfg_wr.same_object_ratio;
    end
  end

  tao_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_rect   (in_rect),
    .ratio     (ratio_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  tao_queue #(
    .DATA_W(DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  tao_back #(
    .MAX_TRACKS(MAX_TRACKS),
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ratio    (ratio_r),
    .q_stat   (q_stat),
    .pop      (pop),
    .pop_data (pop_data),
    .out_res  (out_res)
  );

endmodule

/* test/tb_track_assign_by_overlap_core.sv */
module tb_track_assign_by_overlap_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TRACKS = 64;
  localparam int TAB_W = $clog2(NUM_TRACKS);
  localparam int CRD_W = 12;
  localparam int CYCLE_LIMIT = 1200000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CRD_W:0]   w;
    logic [CRD_W:0]   h;
  } rect_t;

  typedef struct packed {
    logic [tao_pkg::TRACK_INDEX_W-1:0] idx;
    logic                              opened;
    logic                              full;
  } verdict_t;

  logic clk;
  logic rst_n;

  tao_rect_if #(.COORD_BITS(CRD_W)) in_if ();
  tao_result_if out_if ();
  tao_cfg_if cfg_if ();

  track_assign_by_overlap_core #(
    .MAX_TRACKS(NUM_TRACKS),
    .COORD_BITS(CRD_W)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_rect(in_if),
    .out_res(out_if),
    .cfg_wr(cfg_if)
  );

  // predicted track table
  rect_t                       track_tab [NUM_TRACKS];
  int unsigned                 track_cnt;
  logic [tao_pkg::RATIO_W-1:0] ratio_q;

  rect_t    rect_q [$];
  verdict_t verdict_q [$];

  rect_t       tx_cur;
  bit          tx_busy;
  int          tx_gap;
  bit          tx_steady;
  int          rx_gap;
  bit          rx_steady;
  bit          hold_start;
  int          hold_left;
  int unsigned cycle_cnt;
  int          fails;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit same_object(rect_t a, rect_t b);
    rect_t  l;
    rect_t  r;
    longint lx, ly, lw, lh, rx, ry, rh, area, lhs, ra, rb;
    if (a.x > b.x) begin
      l = b;
      r = a;
    end else begin
      l = a;
      r = b;
    end
    lx = longint'(l.x);
    ly = longint'(l.y);
    lw = longint'(l.w);
    lh = longint'(l.h);
    rx = longint'(r.x);
    ry = longint'(r.y);
    rh = longint'(r.h);
    if (lw <= rx - lx) return 1'b0;
    if (ly <= ry && lh > ry - ly) begin
      area = (lx + lw - rx) * (ly + lh - ry);
    end else if (ly >= ry && rh > ly - ry) begin
      area = (lx + lw - rx) * (ry + rh - ly);
    end else begin
      return 1'b0;
    end
    lhs = area * 256;
    ra = longint'(ratio_q) * longint'(a.w) * longint'(a.h);
    rb = longint'(ratio_q) * longint'(b.w) * longint'(b.h);
    return (lhs > ra) || (lhs > rb);
  endfunction

  function automatic verdict_t assign_rect(rect_t rc);
    verdict_t v;
    v = '0;
    for (int i = 0; i < track_cnt; i++) begin
      if (same_object(rc, track_tab[i[TAB_W-1:0]])) begin
        track_tab[i[TAB_W-1:0]] = rc;
        v.idx = i[tao_pkg::TRACK_INDEX_W-1:0];
        return v;
      end
    end
    if (track_cnt < NUM_TRACKS) begin
      track_tab[track_cnt[TAB_W-1:0]] = rc;
      v.idx = track_cnt[tao_pkg::TRACK_INDEX_W-1:0];
      v.opened = 1'b1;
      track_cnt++;
    end else begin
      v.full = 1'b1;
    end
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 88) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 15));
    return int'($urandom_range(30, 120));
  endfunction

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic rect_t make_rect();
    rect_t rc;
    rect_t t;
    int    r, jx, jy, jw, jh;
    r = int'($urandom_range(0, 99));
    if (r < 55 && track_cnt > 0) begin
      // jitter an existing track so most of these land on it
      t = track_tab[TAB_W'($urandom_range(0, track_cnt - 1))];
      jx = int'(t.w) / 4 + 1;
      jy = int'(t.h) / 4 + 1;
      jw = int'(t.w) / 5 + 1;
      jh = int'(t.h) / 5 + 1;
      rc.x = 12'(clip(int'(t.x) + int'($urandom_range(0, 2 * jx)) - jx, 0, 4095));
      rc.y = 12'(clip(int'(t.y) + int'($urandom_range(0, 2 * jy)) - jy, 0, 4095));
      rc.w = 13'(clip(int'(t.w) + int'($urandom_range(0, 2 * jw)) - jw, 1, 4096));
      rc.h = 13'(clip(int'(t.h) + int'($urandom_range(0, 2 * jh)) - jh, 1, 4096));
    end else begin
      rc.x = 12'($urandom_range(0, 4095));
      rc.y = 12'($urandom_range(0, 4095));
      if (r < 85) begin
        rc.w = 13'($urandom_range(1, 64));
        rc.h = 13'($urandom_range(1, 64));
      end else if (r < 95) begin
        rc.w = 13'($urandom_range(1, 512));
        rc.h = 13'($urandom_range(1, 512));
      end else begin
        rc.w = ($urandom_range(0, 3) == 0) ? 13'd4096 : 13'($urandom_range(1, 4096));
        rc.h = ($urandom_range(0, 3) == 0) ? 13'd4096 : 13'($urandom_range(1, 4096));
      end
    end
    return rc;
  endfunction

  task automatic note_fail(input string what, input verdict_t want, input verdict_t got);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s: expected idx=%0d new=%0b full=%0b, got idx=%0d new=%0b full=%0b",
               $realtime, what, want.idx, want.opened, want.full,
               got.idx, got.opened, got.full);
    end
  endtask

  // input driver
  always @(posedge clk) begin : rect_driver
    logic     nv;
    verdict_t pv;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      tx_busy = 1'b0;
      tx_gap = 0;
    end else begin
      nv = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        pv = assign_rect(tx_cur);
        verdict_q.insert(verdict_q.size(), pv);
        nv = 1'b0;
        tx_busy = 1'b0;
      end
      if (!tx_busy) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (rect_q.size() > 0) begin
          tx_cur = rect_q[0];
          rect_q.delete(0);
          tx_busy = 1'b1;
          nv = 1'b1;
          in_if.rect_x <= tx_cur.x;
          in_if.rect_y <= tx_cur.y;
          in_if.rect_width <= tx_cur.w;
          in_if.rect_height <= tx_cur.h;
          tx_gap = tx_steady ? 0 : pick_gap();
        end
      end
      in_if.valid <= nv;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    verdict_t got;
    verdict_t want;
    logic     nr;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.idx = out_if.track_index;
        got.opened = out_if.opened_new;
        got.full = out_if.table_full;
        if (verdict_q.size() == 0) begin
          note_fail("unexpected transaction", '0, got);
        end else begin
          want = verdict_q[0];
          verdict_q.delete(0);
          if (got.idx !== want.idx || got.opened !== want.opened || got.full !== want.full) begin
            note_fail("mismatch", want, got);
          end
        end
        rx_gap = rx_steady ? 0 : pick_gap();
      end
      if (hold_left > 0) begin
        nr = 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      out_if.ready <= nr;
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (rect_q.size() != 0 || tx_busy || verdict_q.size() != 0);
  endtask

  task automatic write_ratio(input logic [tao_pkg::RATIO_W-1:0] r);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.same_object_ratio <= r;
    do @(posedge clk);
    while (!(cfg_if.valid && cfg_if.ready));
    ratio_q = r;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_rect(input int x, input int y, input int w, input int h);
    rect_t rc;
    rc.x = 12'(x);
    rc.y = 12'(y);
    rc.w = 13'(w);
    rc.h = 13'(h);
    rect_q.insert(rect_q.size(), rc);
  endtask

  task automatic run_phase(input logic [tao_pkg::RATIO_W-1:0] ratio, input int n,
                           input bit steady, input bit hold);
    rect_t rc;
    drain();
    write_ratio(ratio);
    @(negedge clk);
    tx_steady = steady;
    rx_steady = ($urandom_range(0, 3) == 0);
    if (hold) begin
      hold_start = 1'b1;
      @(negedge clk);
      hold_start = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      while (rect_q.size() >= 4) @(negedge clk);
      rc = make_rect();
      rect_q.insert(rect_q.size(), rc);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rect_x = '0;
    in_if.rect_y = '0;
    in_if.rect_width = '0;
    in_if.rect_height = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.same_object_ratio = '0;
    ratio_q = tao_pkg::RATIO_RESET;
    track_cnt = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_start = 1'b0;
    cycle_cnt = 0;
    fails = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the reset ratio
    push_rect(0, 0, 1, 1);
    push_rect(0, 0, 1, 1);
    push_rect(4095, 4095, 4096, 4096);
    push_rect(100, 100, 0, 10);
    push_rect(200, 200, 10, 0);
    push_rect(1000, 1000, 100, 100);
    push_rect(1000, 1050, 100, 100);
    push_rect(1050, 950, 100, 100);
    push_rect(1000, 950, 100, 100);
    push_rect(3000, 3000, 400, 400);
    push_rect(3100, 3100, 10, 10);
    push_rect(3000, 100, 50, 50);
    push_rect(3000, 2000, 50, 50);
    push_rect(2000, 2000, 4096, 1);
    push_rect(2000, 2001, 1, 4096);
    push_rect(4095, 0, 1, 4096);
    push_rect(0, 4095, 4096, 1);
    push_rect(500, 500, 0, 0);

    run_phase(9'd0, 150, 1'b0, 1'b0);
    run_phase(9'd256, 150, 1'b1, 1'b1);
    run_phase(9'd511, 150, 1'b0, 1'b0);
    for (int p = 0; p < 4; p++) begin
      run_phase(9'($urandom_range(0, 300)), 90, ($urandom_range(0, 2) == 0), 1'b0);
    end
    run_phase(tao_pkg::RATIO_RESET, 40, 1'b0, 1'b0);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0d expected transactions never arrived", verdict_q.size());
      fails += verdict_q.size();
    end
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
